// ===== src/ewma_pkg.sv =====
`timescale 1ns / 1ps

package ewma_pkg;

    localparam int ALPHA_W    = 16;
    localparam int INTERVAL_W = 12;
    localparam int MODE_W     = 2;
    localparam int EVENT_W    = 16;
    localparam int PERIOD_W   = 12;
    localparam int PENDING_W  = 32;
    localparam int FRAC_W     = 16;
    localparam int RATE_W     = PENDING_W + FRAC_W;
    localparam int SCALED_W   = 60;
    localparam int MUL_A_W    = 32;
    localparam int MUL_B_W    = 16;
    localparam int MUL_P_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W      = 64;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;

    // one quotient bit per divide step
    localparam int DIV_STEPS = RATE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 1'b1;

    // one-minute preset; five- and fifteen-minute presets are 1083 and 363
    localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = 16'd5240;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 12'd5;

    typedef struct packed {
        logic accept_update;
        logic accept_tick;
        logic accept_read;
        logic div_step;
        logic diff_step;
        logic mul_lo;
        logic mul_hi;
        logic mul_read;
        logic smooth_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic loaded;
    } dp_sts_t;

endpackage

// ===== src/ewma_event_rate_meter.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  mode, event_count, period_seconds
// output    out        out_valid/ out_stall scaled_rate, is_initialized
// config    in         wr_en                wr_index, wr_data
//
// Update beats leave the block idle; a new beat is taken the next cycle.
// Read beats make two passes through the shared 32x16 multiplier.
// Tick beats run the 48-step restoring divider (one bit a cycle), then the
// difference, two multiplier passes and the smoothing add; the first tick
// loads the rate in the difference step and ends there.
// Reset clears pending count, rate and loaded flag, and loads the presets.
// A stalled result holds in the output register; a read waits for it to drain.

module ewma_event_rate_meter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [ewma_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [ewma_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [ewma_pkg::MODE_W-1:0]       mode,
    input  logic [ewma_pkg::EVENT_W-1:0]      event_count,
    input  logic [ewma_pkg::PERIOD_W-1:0]     period_seconds,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [ewma_pkg::SCALED_W-1:0]     scaled_rate,
    output logic                              is_initialized
);
    import ewma_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    ewma_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .mode      (mode),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ewma_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .event_count    (event_count),
        .period_seconds (period_seconds),
        .cmd            (cmd),
        .sts            (sts),
        .scaled_rate    (scaled_rate),
        .is_initialized (is_initialized)
    );

    // one datapath operation per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept_tick, cmd.div_step, cmd.diff_step, cmd.mul_lo,
                  cmd.mul_hi, cmd.smooth_step, cmd.out_load}))
        else $error("overlapping datapath commands");

    // never overwrite a result that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result register overwritten");

    // a tick keeps the block busy while it divides
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode == MODE_TICK) |=> in_stall)
        else $error("tick did not start the divider");

    // update beats leave the block ready
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && mode == MODE_UPDATE) |=> !in_stall)
        else $error("update stalled the input");

endmodule

// ===== src/ewma_ctrl.sv =====
`timescale 1ns / 1ps

module ewma_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [ewma_pkg::MODE_W-1:0] mode,
    output logic                       in_stall,
    output logic                       out_valid,
    input  logic                       out_stall,
    input  ewma_pkg::dp_sts_t          sts,
    output ewma_pkg::dp_cmd_t          cmd
);
    import ewma_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIVIDE,
        S_DIFF,
        S_MUL_LO,
        S_MUL_HI,
        S_SMOOTH,
        S_RESULT
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                read_op_reg, read_op_next;
    logic                out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        step_next      = step_reg;
        read_op_next   = read_op_reg;
        cmd.mul_read   = read_op_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (mode)
                        MODE_UPDATE:
                        begin
                            cmd.accept_update = 1'b1;
                        end
                        MODE_TICK:
                        begin
                            cmd.accept_tick = 1'b1;
                            read_op_next    = 1'b0;
                            step_next       = '0;
                            state_next      = S_DIVIDE;
                        end
                        MODE_READ:
                        begin
                            cmd.accept_read = 1'b1;
                            read_op_next    = 1'b1;
                            state_next      = S_MUL_LO;
                        end
                        default:
                        begin
                            // drop the beat
                        end
                    endcase
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = S_DIFF;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DIFF:
            begin
                cmd.diff_step = 1'b1;
                // first tick loads the rate directly
                state_next = sts.loaded ? S_MUL_LO : S_IDLE;
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = read_op_reg ? S_RESULT : S_SMOOTH;
            end
            S_SMOOTH:
            begin
                cmd.smooth_step = 1'b1;
                state_next      = S_IDLE;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            read_op_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            read_op_reg   <= read_op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== src/ewma_dp.sv =====
`timescale 1ns / 1ps

module ewma_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [ewma_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [ewma_pkg::CFG_DATA_W-1:0]   wr_data,
    input  logic [ewma_pkg::EVENT_W-1:0]      event_count,
    input  logic [ewma_pkg::PERIOD_W-1:0]     period_seconds,
    input  ewma_pkg::dp_cmd_t                 cmd,
    output ewma_pkg::dp_sts_t                 sts,
    output logic [ewma_pkg::SCALED_W-1:0]     scaled_rate,
    output logic                              is_initialized
);
    import ewma_pkg::*;

    // control state
    logic [ALPHA_W-1:0]    alpha_reg, alpha_next;
    logic [INTERVAL_W-1:0] interval_reg, interval_next;
    logic [PENDING_W-1:0]  pending_reg, pending_next;
    logic [RATE_W-1:0]     rate_reg, rate_next;
    logic                  loaded_reg, loaded_next;

    // working registers
    logic [INTERVAL_W-1:0] rem_reg, rem_next;
    logic [RATE_W-1:0]     quo_reg, quo_next;
    logic [RATE_W-1:0]     diff_reg, diff_next;
    logic                  up_reg, up_next;
    logic [PERIOD_W-1:0]   period_reg, period_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [SCALED_W-1:0]   scaled_reg, scaled_next;
    logic                  init_reg, init_next;

    logic [PENDING_W:0]    pending_sum;
    logic [INTERVAL_W-1:0] divisor;
    logic [INTERVAL_W:0]   shifted;
    logic [INTERVAL_W:0]   trial;
    logic                  fits;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [MUL_P_W-1:0]    mul_p;
    logic [RATE_W-1:0]     step_mag;
    logic                  step_carry;

    always_comb
    begin
        pending_sum = {1'b0, pending_reg} + {{(PENDING_W + 1 - EVENT_W){1'b0}}, event_count};
        divisor     = (interval_reg == '0) ? INTERVAL_W'(1) : interval_reg;
        shifted     = {rem_reg, quo_reg[RATE_W-1]};
        trial       = shifted - {1'b0, divisor};
        fits        = (shifted >= {1'b0, divisor});

        if (cmd.mul_read)
        begin
            mul_b = {{(MUL_B_W - PERIOD_W){1'b0}}, period_reg};
            mul_a = cmd.mul_hi ? {{(MUL_A_W - (RATE_W - MUL_A_W)){1'b0}},
                                  rate_reg[RATE_W-1:MUL_A_W]}
                               : rate_reg[MUL_A_W-1:0];
        end
        else
        begin
            mul_b = alpha_reg;
            mul_a = cmd.mul_hi ? {{(MUL_A_W - (RATE_W - MUL_A_W)){1'b0}},
                                  diff_reg[RATE_W-1:MUL_A_W]}
                               : diff_reg[MUL_A_W-1:0];
        end
        mul_p = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

        step_mag   = acc_reg[ACC_W-1:FRAC_W];
        step_carry = |acc_reg[FRAC_W-1:0];

        alpha_next    = alpha_reg;
        interval_next = interval_reg;
        pending_next  = pending_reg;
        rate_next     = rate_reg;
        loaded_next   = loaded_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        diff_next     = diff_reg;
        up_next       = up_reg;
        period_next   = period_reg;
        acc_next      = acc_reg;
        scaled_next   = scaled_reg;
        init_next     = init_reg;

        if (wr_en)
        begin
            case (wr_index)
                REG_ALPHA:    alpha_next    = wr_data[ALPHA_W-1:0];
                REG_INTERVAL: interval_next = wr_data[INTERVAL_W-1:0];
                default:      ;
            endcase
        end

        if (cmd.accept_update)
        begin
            pending_next = pending_sum[PENDING_W] ? '1 : pending_sum[PENDING_W-1:0];
        end

        if (cmd.accept_tick)
        begin
            pending_next = '0;
            quo_next     = {pending_reg, {FRAC_W{1'b0}}};
            rem_next     = '0;
        end

        if (cmd.accept_read)
        begin
            period_next = period_seconds;
        end

        if (cmd.div_step)
        begin
            rem_next = fits ? trial[INTERVAL_W-1:0] : shifted[INTERVAL_W-1:0];
            quo_next = {quo_reg[RATE_W-2:0], fits};
        end

        if (cmd.diff_step)
        begin
            if (!loaded_reg)
            begin
                rate_next   = quo_reg;
                loaded_next = 1'b1;
            end
            else
            begin
                up_next   = (quo_reg >= rate_reg);
                diff_next = (quo_reg >= rate_reg) ? quo_reg - rate_reg : rate_reg - quo_reg;
            end
        end

        if (cmd.mul_lo)
        begin
            acc_next = {{(ACC_W - MUL_P_W){1'b0}}, mul_p};
        end

        if (cmd.mul_hi)
        begin
            acc_next = acc_reg + {mul_p[ACC_W-MUL_A_W-1:0], {MUL_A_W{1'b0}}};
        end

        if (cmd.smooth_step)
        begin
            // round the downward step away from zero so the rate floors
            rate_next = up_reg ? rate_reg + step_mag
                               : rate_reg - step_mag - {{(RATE_W - 1){1'b0}}, step_carry};
        end

        if (cmd.out_load)
        begin
            scaled_next = (acc_reg[ACC_W-1:SCALED_W] != '0) ? '1 : acc_reg[SCALED_W-1:0];
            init_next   = loaded_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg    <= ALPHA_RESET;
            interval_reg <= INTERVAL_RESET;
            pending_reg  <= '0;
            rate_reg     <= '0;
            loaded_reg   <= 1'b0;
        end
        else
        begin
            alpha_reg    <= alpha_next;
            interval_reg <= interval_next;
            pending_reg  <= pending_next;
            rate_reg     <= rate_next;
            loaded_reg   <= loaded_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        diff_reg   <= diff_next;
        up_reg     <= up_next;
        period_reg <= period_next;
        acc_reg    <= acc_next;
        scaled_reg <= scaled_next;
        init_reg   <= init_next;
    end

    assign sts.loaded     = loaded_reg;
    assign scaled_rate    = scaled_reg;
    assign is_initialized = init_reg;

endmodule
